>>> sv/lbis_pkg.sv
package lbis_pkg;

  // Event codes carried in in_tuser
  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_REPLY  = 2'd1,
    EV_TICK   = 2'd2,
    EV_UNUSED = 2'd3
  } event_kind_t;

  // Configuration register indexes
  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam int unsigned  CFG_DATA_W      = 16;
  localparam logic [15:0]  TIMEOUT_DEFAULT = 16'd5000;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 192;

  // Result tdata bit positions, lowest field first
  localparam int unsigned O_SEND     = 0;
  localparam int unsigned O_TID_LO   = 1;
  localparam int unsigned O_DEST_LO  = 33;
  localparam int unsigned O_WAIT     = 81;
  localparam int unsigned O_REM_LO   = 82;
  localparam int unsigned O_SENT_LO  = 90;
  localparam int unsigned O_INSEQ_LO = 122;
  localparam int unsigned O_OOSEQ_LO = 154;
  localparam int unsigned O_TIMEOUT  = 186;

endpackage

>>> sv/loopback_initiator_sequencer.sv
// Loopback initiator sequencer. Takes one event per request on the in_
// channel (start, reply, tick) and answers each with exactly one status
// request on the out_ channel. Every event is resolved in the cycle it is
// accepted: the session state updates at that edge and the result lands in
// a single output register, so one event per clock is sustained unless the
// output stalls. The input is stalled only while the output
// register is full and out_tready is low. A start opens a session of
// lbm_count messages to dest_addr and sends the first one at once; each
// in-sequence reply sends the next; tick events count down the reply timer
// loaded from timeout_ticks. Configuration (enable, timeout_ticks) is
// written through cfg_we/cfg_addr/cfg_wdata and should change only while
// the block is idle. All counters wrap.
module loopback_initiator_sequencer
  import lbis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // lbm_count[7:0], dest_addr[55:8], reply_trans_id[87:56], reply_valid[88]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // send_lbm[0], send_trans_id[32:1], send_dest[80:33], waiting[81],
  // remaining[89:82], sent_count[121:90], in_sequence_count[153:122],
  // out_of_sequence_count[185:154], timed_out[186], zero pad above
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic        enable_r;
  logic [15:0] timeout_r;

  // session state
  logic [7:0]  to_send_r,   to_send_nxt;
  logic [31:0] next_id_r,   next_id_nxt;
  logic [31:0] exp_id_r,    exp_id_nxt;
  logic        awaiting_r,  awaiting_nxt;
  logic        running_r,   running_nxt;
  logic [15:0] timer_r,     timer_nxt;
  logic [47:0] dest_r,      dest_nxt;
  logic [31:0] sent_r,      sent_nxt;
  logic [31:0] inseq_r,     inseq_nxt;
  logic [31:0] ooseq_r,     ooseq_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic        accept;
  event_kind_t kind;
  logic [7:0]  req_count;
  logic [47:0] req_dest;
  logic [31:0] req_rid;
  logic        req_rvalid;
  logic        launch;
  logic        expired;
  logic [15:0] timer_dec;
  logic [7:0]  launch_base;   // to_send before the launch decrement
  logic [47:0] launch_dest;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign kind       = event_kind_t'(in_tuser);
  assign req_count  = in_tdata[7:0];
  assign req_dest   = in_tdata[55:8];
  assign req_rid    = in_tdata[87:56];
  assign req_rvalid = in_tdata[88];
  assign timer_dec  = timer_r - 16'd1;

  // event decode and state update
  always_comb begin
    to_send_nxt  = to_send_r;
    next_id_nxt  = next_id_r;
    exp_id_nxt   = exp_id_r;
    awaiting_nxt = awaiting_r;
    running_nxt  = running_r;
    timer_nxt    = timer_r;
    dest_nxt     = dest_r;
    sent_nxt     = sent_r;
    inseq_nxt    = inseq_r;
    ooseq_nxt    = ooseq_r;
    launch       = 1'b0;
    expired      = 1'b0;
    launch_base  = to_send_r;
    launch_dest  = dest_r;

    unique case (kind)
      EV_START: begin
        if (enable_r && (req_count != 8'd0) && !awaiting_r) begin
          launch      = 1'b1;
          launch_base = req_count;
          launch_dest = req_dest;
        end
      end
      EV_REPLY: begin
        if (awaiting_r && req_rvalid) begin
          if (req_rid != exp_id_r) begin
            ooseq_nxt = ooseq_r + 32'd1;
          end else if (running_r) begin
            timer_nxt    = '0;
            awaiting_nxt = 1'b0;
            exp_id_nxt   = exp_id_r + 32'd1;
            inseq_nxt    = inseq_r + 32'd1;
            launch       = (to_send_r != 8'd0);
          end
        end
      end
      EV_TICK: begin
        if (timer_r != 16'd0) begin
          timer_nxt = timer_dec;
          // expiry with messages still queued ends the wait
          if ((timer_dec == 16'd0) && (to_send_r != 8'd0)) begin
            running_nxt  = 1'b0;
            awaiting_nxt = 1'b0;
            expired      = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (launch) begin
      dest_nxt     = launch_dest;
      exp_id_nxt   = next_id_r;
      next_id_nxt  = next_id_r + 32'd1;
      timer_nxt    = timeout_r;
      running_nxt  = 1'b1;
      awaiting_nxt = 1'b1;
      to_send_nxt  = launch_base - 8'd1;
      sent_nxt     = sent_r + 32'd1;
    end

    out_data_nxt = '0;
    out_data_nxt[O_SEND]               = launch;
    out_data_nxt[O_TID_LO +: 32]       = launch ? next_id_r : 32'd0;
    out_data_nxt[O_DEST_LO +: 48]      = launch ? launch_dest : 48'd0;
    out_data_nxt[O_WAIT]               = awaiting_nxt;
    out_data_nxt[O_REM_LO +: 8]        = to_send_nxt;
    out_data_nxt[O_SENT_LO +: 32]      = sent_nxt;
    out_data_nxt[O_INSEQ_LO +: 32]     = inseq_nxt;
    out_data_nxt[O_OOSEQ_LO +: 32]     = ooseq_nxt;
    out_data_nxt[O_TIMEOUT]            = expired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      timeout_r   <= TIMEOUT_DEFAULT;
      to_send_r   <= '0;
      next_id_r   <= '0;
      exp_id_r    <= '0;
      awaiting_r  <= 1'b0;
      running_r   <= 1'b0;
      timer_r     <= '0;
      dest_r      <= '0;
      sent_r      <= '0;
      inseq_r     <= '0;
      ooseq_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENABLE:  enable_r  <= cfg_wdata[0];
          REG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        to_send_r  <= to_send_nxt;
        next_id_r  <= next_id_nxt;
        exp_id_r   <= exp_id_nxt;
        awaiting_r <= awaiting_nxt;
        running_r  <= running_nxt;
        timer_r    <= timer_nxt;
        dest_r     <= dest_nxt;
        sent_r     <= sent_nxt;
        inseq_r    <= inseq_nxt;
        ooseq_r    <= ooseq_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> sv/lbis_checker.sv
module lbis_checker
  import lbis_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side is never blocked while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a sent message always leaves a reply pending
  a_send_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_SEND] |-> out_tdata[O_WAIT])
    else $error("message sent without waiting");

  // a timeout ends the wait and never coincides with a send
  a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_TIMEOUT] |-> !out_tdata[O_WAIT] && !out_tdata[O_SEND])
    else $error("timeout with wait or send set");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind loopback_initiator_sequencer lbis_checker u_lbis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lbis_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_LEN       = 300;
  localparam logic [47:0] DEST_ONES      = 48'hFFFF_FFFF_FFFF;

  // One event offered on the input channel
  typedef struct {
    event_kind_t kind;
    logic [7:0]  count;
    logic [47:0] dest;
    logic [31:0] rid;
    logic        rvalid;
  } lb_req_t;

  // One status request on the output channel, one field per output
  typedef struct {
    logic        send;
    logic [31:0] tid;
    logic [47:0] dest;
    logic        waiting;
    logic [7:0]  remaining;
    logic [31:0] sent;
    logic [31:0] inseq;
    logic [31:0] ooseq;
    logic        timed_out;
  } lb_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // lbm_count[7:0], dest_addr[55:8], reply_trans_id[87:56], reply_valid[88]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // kind[1:0]
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // send_lbm[0], send_trans_id[32:1], send_dest[80:33], waiting[81],
  // remaining[89:82], sent_count[121:90], in_sequence_count[153:122],
  // out_of_sequence_count[185:154], timed_out[186]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_addr = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  loopback_initiator_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow of the initiator: config and session state, kept in step with
  // every request the block accepts.
  // ---------------------------------------------------------------------
  logic        lb_enable  = 1'b1;
  logic [15:0] lb_timeout = TIMEOUT_DEFAULT;

  logic [7:0]  st_to_send     = '0;
  logic [31:0] st_next_id     = '0;
  logic [31:0] st_expected_id = '0;
  logic        st_awaiting    = 1'b0;
  logic        st_wait_run    = 1'b0;
  logic [15:0] st_timer       = '0;
  logic [47:0] st_dest        = '0;
  logic [31:0] st_sent        = '0;
  logic [31:0] st_inseq       = '0;
  logic [31:0] st_ooseq       = '0;

  // Status requests still owed by the block, oldest first
  lb_status_t status_q[$];

  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_orders    = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  // run tallies for the closing summary
  int unsigned n_start = 0, n_reply = 0, n_tick = 0, n_unused = 0;
  int unsigned n_launch = 0, n_expiry = 0;

  // Transmit one LBM: takes next id, arms the reply timer.
  function automatic void launch_lbm(inout lb_status_t r);
    r.send         = 1'b1;
    r.tid          = st_next_id;
    r.dest         = st_dest;
    st_expected_id = st_next_id;
    st_next_id     = st_next_id + 32'd1;
    st_timer       = lb_timeout;
    st_wait_run    = 1'b1;
    st_awaiting    = 1'b1;
    st_to_send     = st_to_send - 8'd1;
    st_sent        = st_sent + 32'd1;
  endfunction

  // Status the block reports for one event; updates the shadow state.
  function automatic lb_status_t predict_status(lb_req_t q);
    lb_status_t r;
    r = '{default: '0};
    case (q.kind)
      EV_START: begin
        // refused when disabled, empty, or a reply is still outstanding
        if (lb_enable && q.count != 8'd0 && !st_awaiting) begin
          st_timer   = '0;
          st_dest    = q.dest;
          st_to_send = q.count;
          launch_lbm(r);
        end
      end
      EV_REPLY: begin
        if (st_awaiting && q.rvalid) begin
          if (q.rid != st_expected_id) begin
            st_ooseq = st_ooseq + 32'd1;
          end else if (st_wait_run) begin
            st_timer       = '0;
            st_awaiting    = 1'b0;
            st_expected_id = st_expected_id + 32'd1;
            st_inseq       = st_inseq + 32'd1;
            if (st_to_send != 8'd0) launch_lbm(r);
          end
        end
      end
      EV_TICK: begin
        // expiry with nothing left just stops the timer; wait goes on
        if (st_timer != 16'd0) begin
          st_timer = st_timer - 16'd1;
          if (st_timer == 16'd0 && st_to_send != 8'd0) begin
            st_wait_run = 1'b0;
            st_awaiting = 1'b0;
            r.timed_out = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.waiting   = st_awaiting;
    r.remaining = st_to_send;
    r.sent      = st_sent;
    r.inseq     = st_inseq;
    r.ooseq     = st_ooseq;
    return r;
  endfunction

  function automatic lb_req_t lb_request(event_kind_t kind, logic [7:0] count,
                                         logic [47:0] dest, logic [31:0] rid,
                                         logic rvalid);
    lb_req_t q;
    q.kind   = kind;
    q.count  = count;
    q.dest   = dest;
    q.rid    = rid;
    q.rvalid = rvalid;
    return q;
  endfunction

  // Mostly well-formed sessions: starts when idle, matching replies and
  // ticks while waiting; the rest is wrong ids, bad frames and noise.
  function automatic lb_req_t random_request();
    lb_req_t     q;
    int unsigned pick;
    pick     = $urandom_range(99);
    q.count  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4, 1));
    q.dest   = {16'($urandom), 32'($urandom)};
    q.rid    = $urandom;
    q.rvalid = 1'($urandom);
    if (!st_awaiting) begin
      if (pick < 60)      q.kind = EV_START;
      else if (pick < 75) q.kind = EV_REPLY;
      else if (pick < 95) q.kind = EV_TICK;
      else                q.kind = EV_UNUSED;
    end else begin
      q.kind = EV_REPLY;
      if (pick < 45) begin
        q.rid    = st_expected_id;
        q.rvalid = 1'b1;
      end else if (pick < 60) begin
        q.rvalid = 1'b1;
      end else if (pick < 68) begin
        q.rid    = st_expected_id;
        q.rvalid = 1'b0;
      end else if (pick < 92) begin
        q.kind = EV_TICK;
      end else if (pick < 97) begin
        q.kind = EV_START;
      end else begin
        q.kind = EV_UNUSED;
      end
    end
    if (q.kind == EV_START && $urandom_range(19) == 0) q.count = 8'd0;
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // Driving side. valid stays high across back-to-back requests; it is
  // only lowered for an idle cycle or a drain.
  // ---------------------------------------------------------------------
  task automatic send_request(input lb_req_t q);
    lb_status_t want;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= q.kind;
    in_tdata  <= {7'd0, q.rvalid, q.rid, q.dest, q.count};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_status(q);
    status_q.push_back(want);
    case (q.kind)
      EV_START: n_start++;
      EV_REPLY: n_reply++;
      EV_TICK:  n_tick++;
      default:  n_unused++;
    endcase
    if (want.send) n_launch++;
    if (want.timed_out) n_expiry++;
  endtask

  // Stop offering and wait until every owed status has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only called with nothing in flight.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_ENABLE) lb_enable = value[0];
    else                   lb_timeout = value;
  endtask

  // ---------------------------------------------------------------------
  // Receiving side: random stalls, plus long hold-offs on order.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_served != hold_orders) begin
      hold_served <= hold_orders;
      hold_left   <= HOLD_LEN;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void compare_field(string name, logic [63:0] want,
                                        logic [63:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name,
                 want, got);
    end
  endfunction

  // Each status request is matched against the oldest owed one.
  always @(posedge clk) begin : status_check
    lb_status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.send      = out_tdata[O_SEND];
      got.tid       = out_tdata[O_TID_LO +: 32];
      got.dest      = out_tdata[O_DEST_LO +: 48];
      got.waiting   = out_tdata[O_WAIT];
      got.remaining = out_tdata[O_REM_LO +: 8];
      got.sent      = out_tdata[O_SENT_LO +: 32];
      got.inseq     = out_tdata[O_INSEQ_LO +: 32];
      got.ooseq     = out_tdata[O_OOSEQ_LO +: 32];
      got.timed_out = out_tdata[O_TIMEOUT];
      if (status_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: status request with none owed: 0x%0h", $realtime, out_tdata);
      end else begin
        want = status_q.pop_front();
        compare_field("send_lbm", 64'(want.send), 64'(got.send));
        compare_field("send_trans_id", 64'(want.tid), 64'(got.tid));
        compare_field("send_dest", 64'(want.dest), 64'(got.dest));
        compare_field("waiting", 64'(want.waiting), 64'(got.waiting));
        compare_field("remaining", 64'(want.remaining), 64'(got.remaining));
        compare_field("sent_count", 64'(want.sent), 64'(got.sent));
        compare_field("in_sequence_count", 64'(want.inseq), 64'(got.inseq));
        compare_field("out_of_sequence_count", 64'(want.ooseq), 64'(got.ooseq));
        compare_field("timed_out", 64'(want.timed_out), 64'(got.timed_out));
      end
    end
  end

  // Watchdog: too long without a request moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved in %0d cycles, %0d status owed",
               quiet_cycles, status_q.size());
      $display("FAIL loopback_initiator_sequencer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Event handling at reset config: idle ticks, unused kind, refused
  // starts, ignored and mismatching replies, a two-message session.
  task automatic test_event_corners();
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_UNUSED, 8'hFF, DEST_ONES, 32'hFFFF_FFFF, 1'b1));
    // reply with nothing outstanding
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b1));
    // zero count is refused
    send_request(lb_request(EV_START, 8'd0, DEST_ONES, 32'd0, 1'b0));
    send_request(lb_request(EV_START, 8'd2, DEST_ONES, 32'd0, 1'b0));
    // start while waiting is refused
    send_request(lb_request(EV_START, 8'hFF, 48'h0000_5A5A_A5A5, 32'd0, 1'b1));
    // matching id but frame failed upstream checks
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b0));
    send_request(lb_request(EV_REPLY, 8'hFF, DEST_ONES, 32'hFFFF_FFFF, 1'b1));
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b1));
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b1));
  endtask

  // Timer and enable extremes: 1-tick expiry with messages left, expiry
  // with none left (wait continues), disabled starts, zero and max timeout.
  task automatic test_timer_corners();
    settle();
    write_reg(REG_TIMEOUT, 16'd1);
    send_request(lb_request(EV_START, 8'hFF, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_START, 8'd1, {16'($urandom), 32'($urandom)}, 32'd0, 1'b0));
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    // late matching reply still closes the wait
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b1));
    settle();
    write_reg(REG_ENABLE, 16'd0);
    send_request(lb_request(EV_START, 8'd1, DEST_ONES, 32'd0, 1'b0));
    settle();
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_TIMEOUT, 16'd0);
    // zero timeout: timer never runs
    send_request(lb_request(EV_START, 8'd1, DEST_ONES, 32'd0, 1'b0));
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b1));
    settle();
    write_reg(REG_TIMEOUT, 16'hFFFF);
    send_request(lb_request(EV_START, 8'd3, {16'($urandom), 32'($urandom)}, 32'd0, 1'b0));
    send_request(lb_request(EV_TICK, 8'd0, 48'd0, 32'd0, 1'b0));
    send_request(lb_request(EV_REPLY, 8'd0, 48'd0, st_expected_id, 1'b1));
  endtask

  // Random sessions under one idle mix and one timeout setting.
  task automatic test_random_sessions(input int unsigned n, input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input logic [15:0] timeout);
    settle();
    write_reg(REG_TIMEOUT, timeout);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_request(random_request());
  endtask

  // Starts refused for a while; replies and ticks keep working.
  task automatic test_enable_off();
    settle();
    write_reg(REG_ENABLE, 16'd0);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    repeat (30) send_request(random_request());
    settle();
    write_reg(REG_ENABLE, 16'd1);
  endtask

  // Receiver holds off long enough for the block to back up and stall
  // its input; then the sender waits for every owed status before more.
  task automatic test_backpressure();
    settle();
    write_reg(REG_TIMEOUT, 16'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_orders <= hold_orders + 1;
    repeat (40) send_request(random_request());
    settle();
    repeat (20) send_request(random_request());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_event_corners();
    test_timer_corners();
    test_random_sessions(220, 0, 0, 16'd3);
    test_random_sessions(200, 86, 0, 16'd1);
    test_random_sessions(200, 0, 86, 16'd4);
    test_random_sessions(200, 30, 30, 16'd2);
    test_enable_off();
    test_backpressure();
    settle();

    $display("Run covered %0d requests: %0d starts, %0d replies, %0d ticks, %0d unused kind",
             n_start + n_reply + n_tick + n_unused, n_start, n_reply, n_tick, n_unused);
    $display("%0d messages launched, %0d reply waits expired; timeouts 0..65535, enable on/off",
             n_launch, n_expiry);
    if (error_count == 0 && status_q.size() == 0) begin
      $display("PASS loopback_initiator_sequencer");
    end else begin
      $display("%0d errors", error_count);
      $display("FAIL loopback_initiator_sequencer");
    end
    $finish;
  end

endmodule
